// ----- hw/rtl/atrs_pkg.sv -----
// Shared types and constants for the ant tour roulette selector.
`default_nettype none
package atrs_pkg;

  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAND_COUNT = 1'd1;

  localparam logic [2:0] OP_WR_PHER = 3'd0;
  localparam logic [2:0] OP_WR_HEUR = 3'd1;
  localparam logic [2:0] OP_WR_CAND = 3'd2;
  localparam logic [2:0] OP_START   = 3'd3;
  localparam logic [2:0] OP_SELECT  = 3'd4;

  localparam logic [8:0] NODE_COUNT_RST = 9'd64;
  localparam logic [4:0] CAND_COUNT_RST = 5'd20;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] value;
    logic [15:0] threshold;
  } in_t;

  typedef struct packed {
    logic [7:0] node;
    logic       tour_done;
    logic       used_fallback;
  } out_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ant_tour_roulette_selector.sv -----
// Ant tour roulette selector: one tour node per select beat from RAM-held tables.
// Write beats (opcodes 0..2) and ignored opcodes give an all-zero result once accepted.
// Start: sweeps the visited RAM, clearing every node but node 0, then gives its result.
// Select: total scan, then threshold scan; a candidate entry walks the candidate, visited
// and table RAM read chain, a fallback entry skips the candidate read; the fallback list
// follows one candidate scan with two node_count scans. Reset starts a clearing sweep.
`default_nettype none
module ant_tour_roulette_selector #(
  parameter int MAX_NODES      = 256,
  parameter int MAX_CANDIDATES = 20,
  parameter int WEIGHT_BITS    = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire atrs_pkg::in_t                   in_data,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output atrs_pkg::out_t                       out_data,
  input  wire logic                            cfg_we,
  input  wire logic [atrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [atrs_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int NODE_W  = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int SLOT_W  = $clog2(MAX_CANDIDATES + 1);
  localparam int IDX_MAX = (MAX_NODES > MAX_CANDIDATES) ? MAX_NODES : MAX_CANDIDATES;
  localparam int IDX_W   = $clog2(IDX_MAX + 1);
  localparam int EW      = (NODE_W > 8) ? NODE_W : 8;
  localparam int SUM_W   = WEIGHT_BITS + $clog2(MAX_NODES + MAX_CANDIDATES + 1);
  localparam int CMP_W   = SUM_W + 16;
  localparam int TAB_D   = MAX_NODES * MAX_NODES;
  localparam int TAB_AW  = $clog2(TAB_D);
  localparam int CAND_D  = MAX_NODES * MAX_CANDIDATES;
  localparam int CAND_AW = $clog2(CAND_D);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RD, S_CAND, S_VIS, S_ACC, S_PASS, S_MUL, S_COMMIT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [NODE_W-1:0] clr_idx_r, clr_idx_nxt;
  logic              start_pend_r, start_pend_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [8:0]        ncfg_r;
  logic [4:0]        ccfg_r;
  logic [15:0]       thr_r, thr_nxt;
  logic              fb_r, fb_nxt;
  logic              pass_r, pass_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              any_r, any_nxt;
  logic [SUM_W-1:0]  total_r, total_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [NODE_W-1:0] last_r, last_nxt;
  logic [NODE_W-1:0] chosen_r, chosen_nxt;
  logic [EW-1:0]     e_r, e_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic              elig_r, elig_nxt;
  logic [CMP_W-1:0]  thr_tot_r, thr_tot_nxt;
  atrs_pkg::out_t    res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  atrs_pkg::out_t    out_data_r, out_data_nxt;

  logic              in_fire;
  logic [CNT_W-1:0]  n_eff;
  logic [SLOT_W-1:0] cc_eff;
  logic [IDX_W-1:0]  limit;
  logic [SUM_W-1:0]  weight;
  logic [SUM_W-1:0]  sum_add;

  logic               ph_we, he_we, cd_we, vis_we;
  logic [TAB_AW-1:0]  tab_waddr, tab_raddr;
  logic [CAND_AW-1:0] cd_waddr, cd_raddr;
  logic [NODE_W-1:0]  vis_waddr, vis_raddr;
  logic               vis_wdata, vis_rdata;
  logic [15:0]        ph_rdata, he_rdata;
  logic [7:0]         cd_rdata;
  logic [EW-1:0]      rd_node;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_eff  = (ncfg_r < 9'd2) ? CNT_W'(2) :
                  ((ncfg_r > MAX_NODES) ? CNT_W'(MAX_NODES) : CNT_W'(ncfg_r));
  assign cc_eff = (ccfg_r > MAX_CANDIDATES) ? SLOT_W'(MAX_CANDIDATES) : SLOT_W'(ccfg_r);
  assign limit  = fb_r ? IDX_W'(n_eff) : IDX_W'(cc_eff);
  assign weight = SUM_W'(prod_r[31 -: WEIGHT_BITS]);
  assign sum_add = sum_r + weight;

  // Write path: table and candidate writes land on the accept edge.
  assign ph_we = in_fire && (in_data.opcode == atrs_pkg::OP_WR_PHER) &&
                 (in_data.row < MAX_NODES) && (in_data.col < MAX_NODES);
  assign he_we = in_fire && (in_data.opcode == atrs_pkg::OP_WR_HEUR) &&
                 (in_data.row < MAX_NODES) && (in_data.col < MAX_NODES);
  assign cd_we = in_fire && (in_data.opcode == atrs_pkg::OP_WR_CAND) &&
                 (in_data.row < MAX_NODES) && (in_data.col < MAX_CANDIDATES);
  assign tab_waddr = TAB_AW'(in_data.row * MAX_NODES + in_data.col);
  assign cd_waddr  = CAND_AW'(in_data.row * MAX_CANDIDATES + in_data.col);

  // Read path: fallback scans walk node indices, candidate scans go through the list.
  assign cd_raddr  = CAND_AW'(cur_r * MAX_CANDIDATES + idx_r);
  assign rd_node   = (state_r == S_CAND) ? EW'(cd_rdata) : EW'(idx_r);
  assign tab_raddr = TAB_AW'(cur_r * MAX_NODES + rd_node);
  assign vis_raddr = NODE_W'(rd_node);

  assign vis_we    = (state_r == S_CLEAR) || (state_r == S_COMMIT);
  assign vis_waddr = (state_r == S_CLEAR) ? clr_idx_r : chosen_r;
  assign vis_wdata = (state_r == S_CLEAR) ? (start_pend_r && (clr_idx_r == '0)) : 1'b1;

  atrs_ram #(.WIDTH(16), .DEPTH(TAB_D)) u_pher (
    .clk(clk), .we(ph_we), .waddr(tab_waddr), .wdata(in_data.value),
    .raddr(tab_raddr), .rdata(ph_rdata)
  );

  atrs_ram #(.WIDTH(16), .DEPTH(TAB_D)) u_heur (
    .clk(clk), .we(he_we), .waddr(tab_waddr), .wdata(in_data.value),
    .raddr(tab_raddr), .rdata(he_rdata)
  );

  atrs_ram #(.WIDTH(8), .DEPTH(CAND_D)) u_cand (
    .clk(clk), .we(cd_we), .waddr(cd_waddr), .wdata(in_data.value[7:0]),
    .raddr(cd_raddr), .rdata(cd_rdata)
  );

  atrs_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
    .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata)
  );

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    start_pend_nxt = start_pend_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    thr_nxt        = thr_r;
    fb_nxt         = fb_r;
    pass_nxt       = pass_r;
    idx_nxt        = idx_r;
    any_nxt        = any_r;
    total_nxt      = total_r;
    sum_nxt        = sum_r;
    last_nxt       = last_r;
    chosen_nxt     = chosen_r;
    e_nxt          = e_r;
    prod_nxt       = prod_r;
    elig_nxt       = elig_r;
    thr_tot_nxt    = thr_tot_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == NODE_W'(MAX_NODES - 1)) begin
          clr_idx_nxt = '0;
          if (start_pend_r) begin
            start_pend_nxt = 1'b0;
            res_nxt        = '0;
            state_nxt      = S_DONE;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          res_nxt   = '0;
          thr_nxt   = in_data.threshold;
          state_nxt = S_DONE;
          case (in_data.opcode)
            atrs_pkg::OP_START: begin
              cur_nxt        = '0;
              rem_nxt        = n_eff - 1'b1;
              start_pend_nxt = 1'b1;
              state_nxt      = S_CLEAR;
            end
            atrs_pkg::OP_SELECT: begin
              if (rem_r == '0) begin
                res_nxt.node      = 8'(cur_r);
                res_nxt.tour_done = 1'b1;
              end else begin
                fb_nxt    = 1'b0;
                pass_nxt  = 1'b0;
                idx_nxt   = '0;
                any_nxt   = 1'b0;
                total_nxt = '0;
                state_nxt = S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RD: begin
        if (idx_r == limit) begin
          state_nxt = S_PASS;
        end else if (fb_r) begin
          e_nxt     = EW'(idx_r);
          state_nxt = S_VIS;
        end else begin
          state_nxt = S_CAND;
        end
      end
      S_CAND: begin
        e_nxt     = EW'(cd_rdata);
        state_nxt = S_VIS;
      end
      S_VIS: begin
        elig_nxt  = (e_r < n_eff) && !vis_rdata;
        prod_nxt  = ph_rdata * he_rdata;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_RD;
        if (elig_r) begin
          if (!pass_r) begin
            total_nxt = total_r + weight;
            any_nxt   = 1'b1;
            last_nxt  = NODE_W'(e_r);
          end else begin
            sum_nxt = sum_add;
            if ({sum_add, 16'b0} >= thr_tot_r) begin
              chosen_nxt = NODE_W'(e_r);
              state_nxt  = S_COMMIT;
            end
          end
        end
      end
      S_PASS: begin
        idx_nxt = '0;
        if (pass_r) begin
          chosen_nxt = last_r;
          state_nxt  = S_COMMIT;
        end else if (!any_r) begin
          if (!fb_r) begin
            fb_nxt    = 1'b1;
            state_nxt = S_RD;
          end else begin
            // nothing left to visit: end the tour in place
            rem_nxt           = '0;
            res_nxt           = '0;
            res_nxt.node      = 8'(cur_r);
            res_nxt.tour_done = 1'b1;
            state_nxt         = S_DONE;
          end
        end else if (total_r == '0) begin
          chosen_nxt = last_r;
          state_nxt  = S_COMMIT;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        thr_tot_nxt = CMP_W'(thr_r) * CMP_W'(total_r);
        pass_nxt    = 1'b1;
        sum_nxt     = '0;
        state_nxt   = S_RD;
      end
      S_COMMIT: begin
        cur_nxt               = chosen_r;
        rem_nxt               = rem_r - 1'b1;
        res_nxt.node          = 8'(chosen_r);
        res_nxt.tour_done     = (rem_r == CNT_W'(1));
        res_nxt.used_fallback = fb_r;
        state_nxt             = S_DONE;
      end
      S_DONE: begin
        // hold the result until the output slot frees up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      start_pend_r <= 1'b0;
      cur_r        <= '0;
      rem_r        <= '0;
      ncfg_r       <= atrs_pkg::NODE_COUNT_RST;
      ccfg_r       <= atrs_pkg::CAND_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      start_pend_r <= start_pend_nxt;
      cur_r        <= cur_nxt;
      rem_r        <= rem_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          atrs_pkg::CFG_NODE_COUNT: ncfg_r <= cfg_wdata;
          atrs_pkg::CFG_CAND_COUNT: ccfg_r <= cfg_wdata[4:0];
          default: begin
          end
        endcase
      end
    end
    thr_r      <= thr_nxt;
    fb_r       <= fb_nxt;
    pass_r     <= pass_nxt;
    idx_r      <= idx_nxt;
    any_r      <= any_nxt;
    total_r    <= total_nxt;
    sum_r      <= sum_nxt;
    last_r     <= last_nxt;
    chosen_r   <= chosen_nxt;
    e_r        <= e_nxt;
    prod_r     <= prod_nxt;
    elig_r     <= elig_nxt;
    thr_tot_r  <= thr_tot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r < CNT_W'(MAX_NODES))
    else $error("remaining count out of range");

  a_commit_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |=> (rem_r == $past(rem_r) - 1'b1))
    else $error("commit did not retire one node");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the delivery state");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |=> (state_r == S_CLEAR || state_r == S_IDLE ||
                              state_r == S_DONE))
    else $error("clear sweep left to a scan state");

endmodule
`default_nettype wire

// ----- hw/rtl/atrs_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module atrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
